>>> rtl/ppurps_pkg.sv
// Shared types and constants for the picture processor register port.
// Item kinds, register numbers and scroll address constants.
// No dependencies.
`default_nettype none

package ppurps_pkg;

  localparam int unsigned AddrW = 15;

  // Start of palette space within the 14-bit video address.
  localparam logic [13:0] PaletteStart = 14'h3F00;
  localparam logic [4:0]  CoarseLast   = 5'd31;
  localparam logic [4:0]  CoarseYWrap  = 5'd29;

  typedef enum logic [3:0] {
    KIND_WRITE     = 4'd0,
    KIND_READ      = 4'd1,
    KIND_INCR_X    = 4'd2,
    KIND_INCR_Y    = 4'd3,
    KIND_COPY_X    = 4'd4,
    KIND_COPY_Y    = 4'd5,
    KIND_VBLANK    = 4'd6,
    KIND_PRERENDER = 4'd7,
    KIND_OVERFLOW  = 4'd8,
    KIND_HIT       = 4'd9,
    KIND_NMI_ACK   = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_e;

endpackage

`default_nettype wire

>>> rtl/ppurps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the sprite memory of the register port.
`default_nettype none

module ppurps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/ppu_register_port_scroll.sv
// Top level of the picture processor CPU register port and scroll logic.
// Depends on ppurps_pkg and ppurps_ram.
//
// Usage:
//   Each input transfer is either a CPU access (write or read of one of the
//   eight registers) or a timing event from the dot counter. Each produces
//   exactly one result transfer carrying read data, the video address before
//   and after the item, the video memory write strobe and data, and the
//   current control, mask, fine X and NMI levels.
//   Both channels use valid and stall; a transfer happens on a clock edge at
//   which valid is high and stall is low.
//   An item is captured in the input register at its transfer and processed
//   into the result register at an edge at which that register is free or
//   being taken. One item is taken every cycle while the receiver does not
//   stall; the sprite memory read is launched at the input transfer so that
//   its registered output is ready for the processing cycle.
//   While the receiver stalls, the result register holds and one further
//   item may wait in the input register; after that the input stalls too.
//   Reset clears the state, flags and addresses. Sprite memory reads as
//   zero at every byte not yet written since reset, through a valid bit per
//   byte; no clearing pass is needed.
`default_nettype none

module ppu_register_port_scroll
  import ppurps_pkg::*;
#(
  parameter int unsigned OBJECT_MEMORY_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [3:0]  kind_i,
  input  wire logic [2:0]  register_index_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [7:0]  vram_read_data_i,
  input  wire logic        flag_value_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  read_data_o,
  output      logic [14:0] access_address_o,
  output      logic [14:0] next_address_o,
  output      logic        vram_write_enable_o,
  output      logic [7:0]  vram_write_data_o,
  output      logic [2:0]  fine_x_out_o,
  output      logic        nmi_pending_o,
  output      logic [7:0]  control_byte_o,
  output      logic [7:0]  mask_byte_o
);

  localparam int unsigned OamAw = $clog2(OBJECT_MEMORY_BYTES);

  // Input register.
  logic        s1_valid_q;
  logic [3:0]  s1_kind_q;
  logic [2:0]  s1_reg_q;
  logic [7:0]  s1_wdata_q;
  logic [7:0]  s1_bus_q;
  logic        s1_flag_q;

  // Architectural state.
  logic [7:0]       ctrl_q, ctrl_d;
  logic [7:0]       mask_q, mask_d;
  logic [2:0]       status_q, status_d;
  logic [AddrW-1:0] cur_q, cur_d;
  logic [AddrW-1:0] tmp_q, tmp_d;
  logic [2:0]       fine_x_q, fine_x_d;
  logic             latch_q, latch_d;
  logic [7:0]       rbuf_q, rbuf_d;
  logic [7:0]       oam_addr_q, oam_addr_d;
  logic             nmi_q, nmi_d;
  logic [OBJECT_MEMORY_BYTES-1:0] oam_valid_q;

  // Sprite memory read path with bypass of the write made at the read edge.
  logic [7:0]       oam_rdata;
  logic             byp_sel_q;
  logic [7:0]       byp_data_q;
  logic [OamAw-1:0] oam_raddr;
  logic             oam_we;
  logic [7:0]       oam_byte;

  // Result register.
  logic             out_valid_q;
  logic [7:0]       rd_q;
  logic [AddrW-1:0] acc_addr_q;
  logic [AddrW-1:0] nxt_addr_q;
  logic             we_q;
  logic [7:0]       wd_q;
  logic [2:0]       fx_q;
  logic             nmi_out_q;
  logic [7:0]       ctrl_out_q;
  logic [7:0]       mask_out_q;

  logic             s1_fire;
  logic             in_fire;
  logic [7:0]       rd_d;
  logic             we_d;
  logic [7:0]       wd_d;

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign oam_we = s1_fire && (s1_kind_q == KIND_WRITE) && (s1_reg_q == REG_OAM_DATA);

  // The read is launched at the input transfer; an item leaving the input
  // register at the same edge may move the sprite address first.
  always_comb begin
    oam_raddr = oam_addr_q[OamAw-1:0];
    if (s1_fire && (s1_kind_q == KIND_WRITE) && (s1_reg_q == REG_OAM_ADDR)) begin
      oam_raddr = s1_wdata_q[OamAw-1:0];
    end
  end

  ppurps_ram #(
    .Width (8),
    .Depth (OBJECT_MEMORY_BYTES)
  ) u_oam (
    .clk_i   (clk_i),
    .we_i    (oam_we),
    .waddr_i (oam_addr_q[OamAw-1:0]),
    .wdata_i (s1_wdata_q),
    .re_i    (in_fire),
    .raddr_i (oam_raddr),
    .rdata_o (oam_rdata)
  );

  always_comb begin
    if (byp_sel_q) begin
      oam_byte = byp_data_q;
    end else if (oam_valid_q[oam_addr_q[OamAw-1:0]]) begin
      oam_byte = oam_rdata;
    end else begin
      oam_byte = 8'h00;
    end
  end

  // Next-state logic for the item in the input register.
  always_comb begin
    logic       render_on;
    logic [4:0] cy;
    logic [AddrW-1:0] step;

    ctrl_d     = ctrl_q;
    mask_d     = mask_q;
    status_d   = status_q;
    cur_d      = cur_q;
    tmp_d      = tmp_q;
    fine_x_d   = fine_x_q;
    latch_d    = latch_q;
    rbuf_d     = rbuf_q;
    oam_addr_d = oam_addr_q;
    nmi_d      = nmi_q;
    rd_d       = 8'h00;
    we_d       = 1'b0;
    wd_d       = 8'h00;
    cy         = cur_q[9:5];
    render_on  = mask_q[3] || mask_q[4];
    step       = ctrl_q[2] ? AddrW'(32) : AddrW'(1);

    unique case (s1_kind_q)
      KIND_WRITE: begin
        unique case (s1_reg_q)
          REG_CTRL: begin
            ctrl_d        = s1_wdata_q;
            tmp_d[11:10]  = s1_wdata_q[1:0];
          end
          REG_MASK:     mask_d = s1_wdata_q;
          REG_OAM_ADDR: oam_addr_d = s1_wdata_q;
          REG_SCROLL: begin
            if (latch_q) begin
              tmp_d[14:12] = s1_wdata_q[2:0];
              tmp_d[9:5]   = s1_wdata_q[7:3];
            end else begin
              tmp_d[4:0] = s1_wdata_q[7:3];
              fine_x_d   = s1_wdata_q[2:0];
            end
            latch_d = !latch_q;
          end
          REG_ADDR: begin
            if (latch_q) begin
              tmp_d[7:0] = s1_wdata_q;
              cur_d      = {tmp_q[14:8], s1_wdata_q};
            end else begin
              tmp_d[14]   = 1'b0;
              tmp_d[13:8] = s1_wdata_q[5:0];
            end
            latch_d = !latch_q;
          end
          REG_DATA: begin
            we_d  = 1'b1;
            wd_d  = s1_wdata_q;
            cur_d = cur_q + step;
          end
          default: ;
        endcase
      end
      KIND_READ: begin
        unique case (s1_reg_q)
          REG_STATUS: begin
            rd_d     = {status_q, rbuf_q[4:0]};
            status_d = {1'b0, status_q[1:0]};
            latch_d  = 1'b0;
          end
          REG_OAM_DATA: rd_d = oam_byte;
          REG_DATA: begin
            rbuf_d = s1_bus_q;
            // Palette reads return the fresh byte rather than the buffer.
            rd_d   = (cur_q[13:0] >= PaletteStart) ? s1_bus_q : rbuf_q;
            cur_d  = cur_q + step;
          end
          default: ;
        endcase
      end
      KIND_INCR_X: begin
        if (render_on) begin
          if (cur_q[4:0] == CoarseLast) begin
            cur_d = {cur_q[14:11], !cur_q[10], cur_q[9:5], 5'd0};
          end else begin
            cur_d = cur_q + AddrW'(1);
          end
        end
      end
      KIND_INCR_Y: begin
        if (render_on) begin
          if (cur_q[14:12] != 3'b111) begin
            cur_d = cur_q + AddrW'(16'h1000);
          end else begin
            // Fine Y wraps into coarse Y; row 29 also flips the vertical
            // nametable, row 31 wraps without flipping and row 30 steps on.
            cur_d = {3'b000, cur_q[11:0]};
            if (cy == CoarseYWrap) begin
              cur_d[11]  = !cur_q[11];
              cur_d[9:5] = 5'd0;
            end else if (cy == CoarseLast) begin
              cur_d[9:5] = 5'd0;
            end else begin
              cur_d[9:5] = cy + 5'd1;
            end
          end
        end
      end
      KIND_COPY_X: begin
        if (render_on) begin
          cur_d[10]  = tmp_q[10];
          cur_d[4:0] = tmp_q[4:0];
        end
      end
      KIND_COPY_Y: begin
        if (render_on) begin
          cur_d[14:11] = tmp_q[14:11];
          cur_d[9:5]   = tmp_q[9:5];
        end
      end
      KIND_VBLANK: begin
        status_d[2] = 1'b1;
        if (ctrl_q[7]) begin
          nmi_d = 1'b1;
        end
      end
      KIND_PRERENDER: status_d = 3'b000;
      KIND_OVERFLOW:  status_d[0] = s1_flag_q;
      KIND_HIT:       status_d[1] = s1_flag_q;
      KIND_NMI_ACK:   nmi_d = 1'b0;
      default: ;
    endcase
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= kind_i;
      s1_reg_q   <= register_index_i;
      s1_wdata_q <= write_data_i;
      s1_bus_q   <= vram_read_data_i;
      s1_flag_q  <= flag_value_i;
      byp_sel_q  <= oam_we;
      byp_data_q <= s1_wdata_q;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      mask_q      <= '0;
      status_q    <= '0;
      cur_q       <= '0;
      tmp_q       <= '0;
      fine_x_q    <= '0;
      latch_q     <= 1'b0;
      rbuf_q      <= '0;
      oam_addr_q  <= '0;
      nmi_q       <= 1'b0;
      oam_valid_q <= '0;
    end else if (s1_fire) begin
      ctrl_q     <= ctrl_d;
      mask_q     <= mask_d;
      status_q   <= status_d;
      cur_q      <= cur_d;
      tmp_q      <= tmp_d;
      fine_x_q   <= fine_x_d;
      latch_q    <= latch_d;
      rbuf_q     <= rbuf_d;
      oam_addr_q <= oam_addr_d;
      nmi_q      <= nmi_d;
      if (oam_we) begin
        oam_valid_q[oam_addr_q[OamAw-1:0]] <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      rd_q       <= rd_d;
      acc_addr_q <= cur_q;
      nxt_addr_q <= cur_d;
      we_q       <= we_d;
      wd_q       <= wd_d;
      fx_q       <= fine_x_d;
      nmi_out_q  <= nmi_d;
      ctrl_out_q <= ctrl_d;
      mask_out_q <= mask_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = rd_q;
  assign access_address_o    = acc_addr_q;
  assign next_address_o      = nxt_addr_q;
  assign vram_write_enable_o = we_q;
  assign vram_write_data_o   = wd_q;
  assign fine_x_out_o        = fx_q;
  assign nmi_pending_o       = nmi_out_q;
  assign control_byte_o      = ctrl_out_q;
  assign mask_byte_o         = mask_out_q;

endmodule

`default_nettype wire
